>>> src/hpq_pkg.sv
// Shared types and codes for the binary heap priority queue.
package hpq_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W  = 2;
   localparam int ST_W   = 2;
   localparam int CNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic [ST_W-1:0]          status;
      logic [CNT_W-1:0]         count;
   } rsp_type;

endpackage

>>> src/hpq_cmp.sv
// Order-aware signed comparator shared by sift-up and sift-down steps.
module hpq_cmp (
   input  logic                                order_mode,
   input  logic signed [hpq_pkg::DATA_W-1:0]   cmp_a,
   input  logic signed [hpq_pkg::DATA_W-1:0]   cmp_b,
   output logic                                a_above_b
);

   // a may sit above b: a >= b for max order, a <= b for min order
   assign a_above_b = order_mode ? (cmp_a >= cmp_b) : (cmp_a <= cmp_b);

endmodule

>>> src/hpq_mem.sv
// Heap element storage: one write port, one registered read port.
module hpq_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                               clock,
   input  logic                               mem_we,
   input  logic [AW-1:0]                      mem_waddr,
   input  logic signed [hpq_pkg::DATA_W-1:0]  mem_wdata,
   input  logic [AW-1:0]                      mem_raddr,
   output logic signed [hpq_pkg::DATA_W-1:0]  mem_rdata
);

   logic signed [hpq_pkg::DATA_W-1:0] store_ff [DEPTH];
   logic signed [hpq_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= store_ff[mem_raddr];
   end

   assign mem_rdata = rdata_ff;

endmodule

>>> src/hpq_seq.sv
// Sequencer for push, pop and clear; drives the heap memory and shared comparator.
module hpq_seq #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               order_mode,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hpq_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [hpq_pkg::DATA_W-1:0]  req_value,
   input  logic                               slot_free,
   output logic                               done,
   output hpq_pkg::rsp_type                   result,
   output logic                               mem_we,
   output logic [AW-1:0]                      mem_waddr,
   output logic signed [hpq_pkg::DATA_W-1:0]  mem_wdata,
   output logic [AW-1:0]                      mem_raddr,
   input  logic signed [hpq_pkg::DATA_W-1:0]  mem_rdata
);

   localparam int NW = AW + 1;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_UP_CMP   = 4'd1;
   localparam logic [3:0] S_UP_FIN   = 4'd2;
   localparam logic [3:0] S_POP_TOP  = 4'd3;
   localparam logic [3:0] S_POP_LAST = 4'd4;
   localparam logic [3:0] S_DN_L     = 4'd5;
   localparam logic [3:0] S_DN_R     = 4'd6;
   localparam logic [3:0] S_DN_CMP   = 4'd7;
   localparam logic [3:0] S_DN_FIN   = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   logic [3:0]                        state_ff, state_in;
   logic [NW-1:0]                     count_ff, count_in;
   logic signed [hpq_pkg::DATA_W-1:0] item_ff, item_in;
   logic signed [hpq_pkg::DATA_W-1:0] child_ff, child_in;
   logic signed [hpq_pkg::DATA_W-1:0] top_ff, top_in;
   logic [hpq_pkg::ST_W-1:0]          status_ff, status_in;
   logic [AW-1:0]                     hole_ff, hole_in;
   logic [AW-1:0]                     left_ff, left_in;
   logic [AW-1:0]                     cidx_ff, cidx_in;

   logic signed [hpq_pkg::DATA_W-1:0] cmp_a, cmp_b;
   logic                              cmp_above;
   logic [AW-1:0]                     idle_par, hole_par, hole_gpar, right_idx;
   logic [NW-1:0]                     next_left, right_ext;
   logic [NW+hpq_pkg::CNT_W-1:0]      count_wide;

   hpq_cmp u_cmp (
      .order_mode (order_mode),
      .cmp_a      (cmp_a),
      .cmp_b      (cmp_b),
      .a_above_b  (cmp_above)
   );

   assign idle_par  = (count_ff[AW-1:0] - AW'(1)) >> 1;
   assign hole_par  = (hole_ff - AW'(1)) >> 1;
   assign hole_gpar = (hole_par - AW'(1)) >> 1;
   assign right_idx = left_ff + AW'(1);
   assign right_ext = {1'b0, left_ff} + NW'(1);
   assign next_left = {cidx_ff, 1'b1};

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      item_in   = item_ff;
      child_in  = child_ff;
      top_in    = top_ff;
      status_in = status_ff;
      hole_in   = hole_ff;
      left_in   = left_ff;
      cidx_in   = cidx_ff;
      mem_we    = 1'b0;
      mem_waddr = hole_ff;
      mem_wdata = item_ff;
      mem_raddr = '0;
      cmp_a     = item_ff;
      cmp_b     = child_ff;
      done      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            mem_raddr = (req_cmd == hpq_pkg::CMD_PUSH) ? idle_par : '0;
            if (req_valid) begin
               top_in    = '0;
               status_in = hpq_pkg::ST_DONE;
               item_in   = req_value;
               state_in  = S_DONE;
               unique case (req_cmd)
                  hpq_pkg::CMD_PUSH: begin
                     if (count_ff >= NW'(DEPTH)) begin
                        status_in = hpq_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + NW'(1);
                        hole_in  = count_ff[AW-1:0];
                        state_in = (count_ff == '0) ? S_UP_FIN : S_UP_CMP;
                     end
                  end
                  hpq_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        status_in = hpq_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - NW'(1);
                        hole_in  = '0;
                        state_in = S_POP_TOP;
                     end
                  end
                  hpq_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_UP_CMP: begin
            cmp_a     = mem_rdata;
            cmp_b     = item_ff;
            mem_we    = 1'b1;
            mem_waddr = hole_ff;
            if (cmp_above) begin
               mem_wdata = item_ff;
               state_in  = S_DONE;
            end else begin
               mem_wdata = mem_rdata;
               hole_in   = hole_par;
               mem_raddr = hole_gpar;
               if (hole_par == '0) begin
                  state_in = S_UP_FIN;
               end
            end
         end
         S_UP_FIN: begin
            mem_we   = 1'b1;
            state_in = S_DONE;
         end
         S_POP_TOP: begin
            top_in    = mem_rdata;
            mem_raddr = count_ff[AW-1:0];
            state_in  = S_POP_LAST;
         end
         S_POP_LAST: begin
            item_in = mem_rdata;
            if (count_ff > NW'(1)) begin
               mem_raddr = AW'(1);
               left_in   = AW'(1);
               state_in  = S_DN_L;
            end else begin
               mem_we    = (count_ff != '0);
               mem_waddr = '0;
               mem_wdata = mem_rdata;
               state_in  = S_DONE;
            end
         end
         S_DN_L: begin
            child_in = mem_rdata;
            cidx_in  = left_ff;
            if (right_ext < count_ff) begin
               mem_raddr = right_idx;
               state_in  = S_DN_R;
            end else begin
               state_in  = S_DN_CMP;
            end
         end
         S_DN_R: begin
            cmp_a = child_ff;
            cmp_b = mem_rdata;
            if (!cmp_above) begin
               child_in = mem_rdata;
               cidx_in  = right_idx;
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            mem_we = 1'b1;
            if (cmp_above) begin
               state_in = S_DONE;
            end else begin
               mem_wdata = child_ff;
               hole_in   = cidx_ff;
               if (next_left < count_ff) begin
                  left_in   = next_left[AW-1:0];
                  mem_raddr = next_left[AW-1:0];
                  state_in  = S_DN_L;
               end else begin
                  state_in  = S_DN_FIN;
               end
            end
         end
         S_DN_FIN: begin
            mem_we   = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      child_ff  <= child_in;
      top_ff    <= top_in;
      status_ff <= status_in;
      hole_ff   <= hole_in;
      left_ff   <= left_in;
      cidx_ff   <= cidx_in;
   end

   assign count_wide       = (NW + hpq_pkg::CNT_W)'(count_ff);
   assign result.top_value = top_ff;
   assign result.status    = status_ff;
   assign result.count     = count_wide[hpq_pkg::CNT_W-1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(DEPTH))
      else $error("element count above depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == hpq_pkg::CMD_PUSH && count_ff < NW'(DEPTH))
      |=> count_ff == $past(count_ff) + NW'(1))
      else $error("push did not grow count");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == hpq_pkg::CMD_POP && count_ff != '0)
      |=> count_ff == $past(count_ff) - NW'(1))
      else $error("pop did not shrink count");

   a_write_live: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> NW'(mem_waddr) < count_ff)
      else $error("write outside live heap");

endmodule

>>> src/binary_heap_priority_queue_top.sv
// Top level of the binary heap priority queue.
//
//  channel | ports           | direction | payload
//  req     | req_t*          | in        | tuser: cmd; tdata: value
//  rsp     | rsp_t*          | out       | tuser: status; tdata: top_value, count
//  csr     | csr_*           | in        | data: order_mode
//
// Push walks up at most log2(HEAP_DEPTH) levels; pop with more than one element
// left walks down from the root until it stops at a compare or reaches a leaf,
// reading the right child only where one exists; clear and refusals do no walk.
// The memory has a single read port, so the walk reads one element per step.
// Reset empties the heap and selects min order; memory contents are not cleared.
// A waiting result in the output register does not stop the next item from starting.
module binary_heap_priority_queue_top #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] top_value, [38:32] count, [39] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // order_mode
);

   localparam int AW = $clog2(HEAP_DEPTH);

   logic                              order_ff;
   logic                              rsp_valid_ff;
   hpq_pkg::rsp_type                  rsp_ff;
   logic                              slot_free;
   logic                              done;
   hpq_pkg::rsp_type                  result;
   logic                              mem_we;
   logic [AW-1:0]                     mem_waddr;
   logic signed [hpq_pkg::DATA_W-1:0] mem_wdata;
   logic [AW-1:0]                     mem_raddr;
   logic signed [hpq_pkg::DATA_W-1:0] mem_rdata;

   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            order_ff <= csr_data;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   hpq_mem #(
      .DEPTH (HEAP_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   hpq_seq #(
      .DEPTH (HEAP_DEPTH),
      .AW    (AW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .order_mode (order_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser),
      .req_value  (req_tdata),
      .slot_free  (slot_free),
      .done       (done),
      .result     (result),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.count, rsp_ff.top_value};
   assign rsp_tuser  = rsp_ff.status;

endmodule
